// ===== sv/gb3_pkg.sv =====
// shared types and constants of the 3x3 gaussian blur
package gb3_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int CHANNELS      = 3;
  localparam int WEIGHT_BITS   = 16;
  localparam int PIX_W         = 8;
  localparam int DIM_W         = 13;
  localparam int POS_W         = 12;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 3;
  localparam int SUM_W         = PIX_W + 2;
  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 4;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam logic [WEIGHT_BITS-1:0] CORNER_RST = WEIGHT_BITS'(4922);
  localparam logic [WEIGHT_BITS-1:0] SIDE_RST   = WEIGHT_BITS'(8116);
  localparam logic [WEIGHT_BITS-1:0] CENTER_RST = WEIGHT_BITS'(13381);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CORNER_WEIGHT = 3'd2,
    REG_EDGE_WEIGHT   = 3'd3,
    REG_CENTER_WEIGHT = 3'd4
  } gb3_reg_t;

  typedef logic [CHANNELS-1:0][PIX_W-1:0] gb3_pix_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } gb3_dim_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] corner_wt;
    logic [WEIGHT_BITS-1:0] side_wt;
    logic [WEIGHT_BITS-1:0] center_wt;
  } gb3_wgt_t;

  typedef struct packed {
    logic [CHANNELS-1:0][SUM_W-1:0] corners;
    logic [CHANNELS-1:0][SUM_W-1:0] sides;
    logic [CHANNELS-1:0][PIX_W-1:0] centre;
    logic [POS_W-1:0]               row;
    logic [POS_W-1:0]               col;
    logic                           last;
  } gb3_win_t;

  typedef struct packed {
    gb3_pix_t         pix;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } gb3_res_t;

endpackage

// ===== sv/gaussian_blur_3x3_rgb.sv =====
// top level of the 3x3 gaussian blur on an rgb pixel stream
//
// Input side is a queue: present a pixel with push while full is low; one
// pixel per clock is taken back to back. Pixels come in raster order, and
// in_frame_start marks row 0, column 0 of a frame. Results come out of a
// queue: while empty is low the oldest filtered pixel sits on the out_
// ports, and pop takes it. Only interior pixels produce a result; border
// pixels are absorbed without one. out_frame_last flags the last interior
// pixel of a frame.
// Each result passes the window stage, middle queue, product stage and result queue.
// Throughput is one pixel per clock: each line store takes one read and one
// write per pixel on separate ports. A stalled receiver fills the result
// queue, then the middle queue, and then full rises; nothing is dropped.
// The cfg_ port writes size and Q0.16 weights; write only while idle.
// Synchronous reset clears position, window, queues and sets default
// registers; line store contents are not cleared and need no clearing pass.
module gaussian_blur_3x3_rgb #(
  parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [gb3_pkg::PIX_W-1:0]         in_blue_in,
  input  logic [gb3_pkg::PIX_W-1:0]         in_green_in,
  input  logic [gb3_pkg::PIX_W-1:0]         in_red_in,
  input  logic                              in_frame_start,
  output logic                              empty,
  input  logic                              pop,
  output logic [gb3_pkg::PIX_W-1:0]         out_blue_out,
  output logic [gb3_pkg::PIX_W-1:0]         out_green_out,
  output logic [gb3_pkg::PIX_W-1:0]         out_red_out,
  output logic [gb3_pkg::POS_W-1:0]         out_row,
  output logic [gb3_pkg::POS_W-1:0]         out_col,
  output logic                              out_frame_last,
  input  logic                              cfg_we,
  input  logic [gb3_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DIM_W   = gb3_pkg::DIM_W;
  localparam int WB      = gb3_pkg::WEIGHT_BITS;
  localparam int DIM_TOP = (1 << DIM_W) - 1;
  localparam int W_HI    = (MAX_WIDTH < DIM_TOP) ? MAX_WIDTH : DIM_TOP;
  localparam int W_RST   = (gb3_pkg::WIDTH_RST > W_HI) ? W_HI : gb3_pkg::WIDTH_RST;
  localparam logic [DIM_W-1:0] W_MAX = DIM_W'(W_HI);
  localparam logic [DIM_W-1:0] H_MAX = DIM_W'(gb3_pkg::MAX_HEIGHT);
  localparam int MID_CNT_W = $clog2(gb3_pkg::MID_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(gb3_pkg::OUT_DEPTH + 1);

  gb3_pkg::gb3_dim_t dim_r;
  gb3_pkg::gb3_wgt_t wgt_r;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(gb3_pkg::MIN_DIM)) begin
      r = DIM_W'(gb3_pkg::MIN_DIM);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // sizes are stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r.width   <= DIM_W'(W_RST);
      dim_r.height  <= DIM_W'(gb3_pkg::HEIGHT_RST);
      wgt_r.corner_wt <= gb3_pkg::CORNER_RST;
      wgt_r.side_wt   <= gb3_pkg::SIDE_RST;
      wgt_r.center_wt <= gb3_pkg::CENTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gb3_pkg::REG_IMAGE_WIDTH:   dim_r.width     <= clamp_dim(cfg_wdata[DIM_W-1:0], W_MAX);
        gb3_pkg::REG_IMAGE_HEIGHT:  dim_r.height    <= clamp_dim(cfg_wdata[DIM_W-1:0], H_MAX);
        gb3_pkg::REG_CORNER_WEIGHT: wgt_r.corner_wt <= cfg_wdata[WB-1:0];
        gb3_pkg::REG_EDGE_WEIGHT:   wgt_r.side_wt   <= cfg_wdata[WB-1:0];
        gb3_pkg::REG_CENTER_WEIGHT: wgt_r.center_wt <= cfg_wdata[WB-1:0];
        default: ;
      endcase
    end
  end

  logic              acc;
  logic              s1_valid;
  logic              win_valid;
  gb3_pkg::gb3_win_t win_in, win_out;
  gb3_pkg::gb3_pix_t pix;
  logic              mid_empty, mid_full, mid_pop;
  logic [MID_CNT_W-1:0] mid_count;
  logic              res_push;
  gb3_pkg::gb3_res_t res_in, res_out;
  logic              out_full, out_pop;
  logic [OUT_CNT_W-1:0] out_count;

  // a pixel in the window stage may still add one entry to the middle queue
  assign full = (MID_CNT_W'(mid_count) + MID_CNT_W'(s1_valid))
                >= MID_CNT_W'(gb3_pkg::MID_DEPTH);
  assign acc  = push && !full;

  assign pix[0] = in_blue_in;
  assign pix[1] = in_green_in;
  assign pix[2] = in_red_in;

  gb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .dim         (dim_r),
    .acc         (acc),
    .pix         (pix),
    .frame_start (in_frame_start),
    .s1_valid    (s1_valid),
    .win_valid   (win_valid),
    .win         (win_in)
  );

  gb3_queue #(.WIDTH($bits(gb3_pkg::gb3_win_t)), .DEPTH(gb3_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (win_valid),
    .wdata (win_in),
    .pop   (mid_pop),
    .rdata (win_out),
    .empty (mid_empty),
    .full  (mid_full),
    .count (mid_count)
  );

  gb3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wgt       (wgt_r),
    .win_empty (mid_empty),
    .win       (win_out),
    .out_count (out_count),
    .win_pop   (mid_pop),
    .res_push  (res_push),
    .res       (res_in)
  );

  assign out_pop = pop && !empty;

  gb3_queue #(.WIDTH($bits(gb3_pkg::gb3_res_t)), .DEPTH(gb3_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  assign out_blue_out   = res_out.pix[0];
  assign out_green_out  = res_out.pix[1];
  assign out_red_out    = res_out.pix[2];
  assign out_row        = res_out.row;
  assign out_col        = res_out.col;
  assign out_frame_last = res_out.last;

  a_mid_credit: assert property (@(posedge clk) disable iff (!rst_n)
    win_valid |-> !mid_full)
    else $error("window request arrived with no room in the middle queue");
  a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !out_full)
    else $error("result request arrived with no room in the result queue");
  a_front_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_valid)
    else $error("accepted pixel did not reach the window stage");

endmodule

// ===== sv/gb3_ram.sv =====
// generic single write port ram with registered read (old data on collision)
module gb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/gb3_queue.sv =====
// small register fifo with occupancy count
module gb3_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign count = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count out of step with pushes");

endmodule

// ===== sv/gb3_front.sv =====
// front end: raster position, line stores, 3x3 window and per-channel neighbor sums
module gb3_front #(
  parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gb3_pkg::gb3_dim_t dim,
  input  logic              acc,
  input  gb3_pkg::gb3_pix_t pix,
  input  logic              frame_start,
  output logic              s1_valid,
  output logic              win_valid,
  output gb3_pkg::gb3_win_t win
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = (ADDR_W > gb3_pkg::DIM_W) ? gb3_pkg::DIM_W : ADDR_W;
  localparam int CMP_W  = gb3_pkg::DIM_W + 1;
  localparam int POS_W  = gb3_pkg::POS_W;
  localparam int DIM_W  = gb3_pkg::DIM_W;
  localparam int SUM_W  = gb3_pkg::SUM_W;
  localparam int PIX_BITS = $bits(gb3_pkg::gb3_pix_t);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  logic [COL_W-1:0] c0, c1;
  logic [COL_W:0]   cn;
  logic [POS_W-1:0] r0, r2;
  logic [DIM_W-1:0] r1, rn;
  logic             col_wrap, end_row, emit, last;

  logic             s1_v_r;
  logic [COL_W-1:0] s1_col_r;
  logic [POS_W-1:0] s1_row_r;
  logic             s1_emit_r, s1_last_r;
  gb3_pkg::gb3_pix_t s1_pix_r;
  logic             byp_v_r;
  gb3_pkg::gb3_pix_t byp_up_r, byp_mid_r;

  gb3_pkg::gb3_pix_t up_rd, mid_rd, up_cur, mid_cur;
  gb3_pkg::gb3_pix_t win_r [6];

  // position of the incoming pixel and of the one after it
  always_comb begin
    c0       = frame_start ? '0 : col_r;
    r0       = frame_start ? '0 : row_r;
    col_wrap = CMP_W'(c0) >= CMP_W'(dim.width);
    c1       = col_wrap ? '0 : c0;
    r1       = col_wrap ? ({1'b0, r0} + DIM_W'(1)) : {1'b0, r0};
    r2       = (r1 >= dim.height) ? '0 : r1[POS_W-1:0];
    cn       = {1'b0, c1} + (COL_W + 1)'(1);
    end_row  = CMP_W'(cn) >= CMP_W'(dim.width);
    rn       = {1'b0, r2} + DIM_W'(1);
    if (end_row) begin
      col_nxt = '0;
      row_nxt = (rn >= dim.height) ? '0 : rn[POS_W-1:0];
    end else begin
      col_nxt = cn[COL_W-1:0];
      row_nxt = r2;
    end
    emit = (r2 >= POS_W'(2)) && (c1 >= COL_W'(2));
    last = ({1'b0, r2} == dim.height - DIM_W'(1)) &&
           (CMP_W'(c1) == CMP_W'(dim.width) - CMP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // the store read for this pixel misses a write made in the same cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r  <= c1;
      s1_row_r  <= r2;
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_pix_r  <= pix;
      byp_v_r   <= s1_v_r && (s1_col_r == c1);
      byp_up_r  <= mid_cur;
      byp_mid_r <= s1_pix_r;
    end
  end

  assign up_cur  = byp_v_r ? byp_up_r : up_rd;
  assign mid_cur = byp_v_r ? byp_mid_r : mid_rd;

  gb3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (ADDR_W'(s1_col_r)),
    .wdata (mid_cur),
    .raddr (ADDR_W'(c1)),
    .rdata (up_rd)
  );

  gb3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (ADDR_W'(s1_col_r)),
    .wdata (s1_pix_r),
    .raddr (ADDR_W'(c1)),
    .rdata (mid_rd)
  );

  // window: entries 0..2 hold column c-2 top to bottom, 3..5 column c-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up_cur;
      win_r[4] <= mid_cur;
      win_r[5] <= s1_pix_r;
    end
  end

  always_comb begin
    for (int k = 0; k < gb3_pkg::CHANNELS; k++) begin
      win.corners[k] = SUM_W'(win_r[0][k]) + SUM_W'(win_r[2][k])
                     + SUM_W'(up_cur[k]) + SUM_W'(s1_pix_r[k]);
      win.sides[k]   = SUM_W'(win_r[3][k]) + SUM_W'(win_r[5][k])
                     + SUM_W'(win_r[1][k]) + SUM_W'(mid_cur[k]);
      win.centre[k]  = win_r[4][k];
    end
    win.row  = s1_row_r - POS_W'(1);
    win.col  = POS_W'(s1_col_r) - POS_W'(1);
    win.last = s1_last_r;
  end

  assign win_valid = s1_v_r && s1_emit_r;
  assign s1_valid  = s1_v_r;

endmodule

// ===== sv/gb3_back.sv =====
// back end: weight multiply, sum, shift and saturate per channel
module gb3_back (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  gb3_pkg::gb3_wgt_t                         wgt,
  input  logic                                      win_empty,
  input  gb3_pkg::gb3_win_t                         win,
  input  logic [$clog2(gb3_pkg::OUT_DEPTH+1)-1:0]   out_count,
  output logic                                      win_pop,
  output logic                                      res_push,
  output gb3_pkg::gb3_res_t                         res
);

  localparam int WB    = gb3_pkg::WEIGHT_BITS;
  localparam int SUM_W = gb3_pkg::SUM_W;
  localparam int PIX_W = gb3_pkg::PIX_W;
  localparam int CH    = gb3_pkg::CHANNELS;
  localparam int CP_W  = SUM_W + WB;
  localparam int MP_W  = PIX_W + WB;
  localparam int ACC_W = CP_W + 2;
  localparam int CNT_W = $clog2(gb3_pkg::OUT_DEPTH + 1);
  localparam int HI_W  = ACC_W - WB;

  logic                       b0_v_r;
  logic [CH-1:0][CP_W-1:0]    pc_r, pe_r;
  logic [CH-1:0][MP_W-1:0]    pm_r;
  logic [gb3_pkg::POS_W-1:0]  row_r, col_r;
  logic                       last_r;
  logic [ACC_W-1:0]           acc_sum;
  logic [HI_W-1:0]            scaled;

  // room is reserved in the result queue for the product stage
  assign win_pop = !win_empty && ((out_count + CNT_W'(b0_v_r)) < CNT_W'(gb3_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
    end else begin
      b0_v_r <= win_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (win_pop) begin
      for (int k = 0; k < CH; k++) begin
        pc_r[k] <= CP_W'(win.corners[k]) * CP_W'(wgt.corner_wt);
        pe_r[k] <= CP_W'(win.sides[k]) * CP_W'(wgt.side_wt);
        pm_r[k] <= MP_W'(win.centre[k]) * MP_W'(wgt.center_wt);
      end
      row_r  <= win.row;
      col_r  <= win.col;
      last_r <= win.last;
    end
  end

  always_comb begin
    acc_sum = '0;
    scaled  = '0;
    for (int k = 0; k < CH; k++) begin
      acc_sum = ACC_W'(pc_r[k]) + ACC_W'(pe_r[k]) + ACC_W'(pm_r[k]);
      scaled  = acc_sum[ACC_W-1:WB];
      res.pix[k] = (scaled > HI_W'(255)) ? PIX_W'(255) : scaled[PIX_W-1:0];
    end
    res.row  = row_r;
    res.col  = col_r;
    res.last = last_r;
  end

  assign res_push = b0_v_r;

endmodule
